// ----- rtl/threshold_binarize_dark_centroid_defines.svh -----
// Assertion macros for the threshold binarize and dark centroid block.
`ifndef THRESHOLD_BINARIZE_DARK_CENTROID_DEFINES_SVH
`define THRESHOLD_BINARIZE_DARK_CENTROID_DEFINES_SVH

`ifndef ASSERT_OFF
`define TBDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TBDC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TBDC_ASSERT(lbl, prop, msg)
`define TBDC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/tbdc_pkg.sv -----
// Package with widths, constants, types and helpers of the threshold centroid block.
package tbdc_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_COLS   = 2048;
  localparam int MAX_ROWS   = 2048;
  localparam int POS_W      = 11;
  localparam int CNT_W      = 23;
  localparam int SUM_W      = 34;
  localparam int DIV_CNT_W  = $clog2(SUM_W);
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [POS_W-1:0]     COL_LAST    = POS_W'(MAX_COLS - 1);
  localparam logic [POS_W-1:0]     ROW_LAST    = POS_W'(MAX_ROWS - 1);
  localparam logic [CNT_W-1:0]     CNT_MAX     = '1;
  localparam logic [PIX_W-1:0]     THR_RESET   = 8'd102;
  localparam logic [PIX_W-1:0]     PIX_BRIGHT  = 8'hFF;
  localparam logic [PIX_W-1:0]     PIX_DARK    = 8'h00;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(SUM_W - 1);
  localparam logic                 REG_THRESHOLD = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_DIV_COL = 3'b010,
    ST_DIV_ROW = 3'b100
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
  } acc_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [POS_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

// ----- rtl/tbdc_accum.sv -----
// Position counters and dark pixel count and sum accumulators.
module tbdc_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               dark_i,
  input  logic               eol_i,
  input  logic               eof_i,
  output tbdc_pkg::acc_t     nxt_o
);

  logic [tbdc_pkg::POS_W-1:0] col_pos_q, row_pos_q;
  logic [tbdc_pkg::CNT_W-1:0] cnt_q;
  logic [tbdc_pkg::SUM_W-1:0] col_sum_q, row_sum_q;
  logic                       add_en;

  assign add_en = step_i && dark_i && (cnt_q != tbdc_pkg::CNT_MAX);

  always_comb begin
    nxt_o.count   = add_en ? cnt_q + tbdc_pkg::CNT_W'(1) : cnt_q;
    nxt_o.col_sum = add_en ? tbdc_pkg::sat_add(col_sum_q, col_pos_q) : col_sum_q;
    nxt_o.row_sum = add_en ? tbdc_pkg::sat_add(row_sum_q, row_pos_q) : row_sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
      cnt_q     <= '0;
      col_sum_q <= '0;
      row_sum_q <= '0;
    end else if (step_i) begin
      if (eof_i) begin
        col_pos_q <= '0;
        row_pos_q <= '0;
        cnt_q     <= '0;
        col_sum_q <= '0;
        row_sum_q <= '0;
      end else begin
        cnt_q     <= nxt_o.count;
        col_sum_q <= nxt_o.col_sum;
        row_sum_q <= nxt_o.row_sum;
        if (eol_i) begin
          col_pos_q <= '0;
          if (row_pos_q != tbdc_pkg::ROW_LAST) begin
            row_pos_q <= row_pos_q + tbdc_pkg::POS_W'(1);
          end
        end else if (col_pos_q != tbdc_pkg::COL_LAST) begin
          col_pos_q <= col_pos_q + tbdc_pkg::POS_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/tbdc_div.sv -----
// Shared restoring divider that yields one quotient bit per cycle.
module tbdc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tbdc_pkg::div_req_t   req_i,
  output tbdc_pkg::div_rsp_t   rsp_o
);

  logic                           busy_q;
  logic [tbdc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [tbdc_pkg::SUM_W-1:0]     dvd_q;
  logic [tbdc_pkg::CNT_W-1:0]     dsr_q;
  logic [tbdc_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic [tbdc_pkg::POS_W-1:0]     quo_q;
  logic [tbdc_pkg::CNT_W:0]       trial;
  logic                           qbit;

  always_comb begin
    trial = {rem_q, dvd_q[tbdc_pkg::SUM_W-1]};
    qbit  = trial >= {1'b0, dsr_q};
    rem_d = qbit ? tbdc_pkg::CNT_W'(trial - {1'b0, dsr_q}) : trial[tbdc_pkg::CNT_W-1:0];
  end

  assign rsp_o.done = busy_q && (cnt_q == tbdc_pkg::DIV_LAST);
  assign rsp_o.quot = {quo_q[tbdc_pkg::POS_W-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= !rsp_o.done;
      cnt_q  <= cnt_q + tbdc_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[tbdc_pkg::SUM_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= rsp_o.quot;
    end
  end

endmodule

// ----- rtl/threshold_binarize_dark_centroid.sv -----
// Top level of the threshold binarize and dark centroid block.
//
//   channel | direction | handshake             | payload
//   in      | request   | in_valid_i/in_stall_o | pixel, end_of_line, end_of_frame
//   out     | result    | out_valid_o/out_stall_i | binary_pixel, centroid fields
//   config  | APB write | psel/penable/pready   | threshold_level at address 0
//
// A pixel that does not end a frame, or ends one without dark pixels, loads the output register when accepted.
// A frame end with dark pixels runs two 34-step divisions through one shared divider,
// so its result appears once both divisions are done and no request is taken meanwhile.
// Reset clears the counters, the sequencer and the output valid and loads threshold 102.
// A stalled result holds the output register, and then no new request is accepted.
`include "threshold_binarize_dark_centroid_defines.svh"

module threshold_binarize_dark_centroid (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tbdc_pkg::PIX_W-1:0]      pixel_i,
  input  logic                            end_of_line_i,
  input  logic                            end_of_frame_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tbdc_pkg::PIX_W-1:0]      binary_pixel_o,
  output logic                            centroid_valid_o,
  output logic                            dark_found_o,
  output logic [tbdc_pkg::POS_W-1:0]      centroid_col_o,
  output logic [tbdc_pkg::POS_W-1:0]      centroid_row_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbdc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tbdc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tbdc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  tbdc_pkg::state_e           state_q, state_d;
  logic [tbdc_pkg::PIX_W-1:0] thr_q;
  logic [tbdc_pkg::PIX_W-1:0] bin_q;
  logic [tbdc_pkg::SUM_W-1:0] row_sum_q;
  logic [tbdc_pkg::CNT_W-1:0] count_q;
  logic [tbdc_pkg::POS_W-1:0] col_q;
  logic                       out_valid_q;
  logic [tbdc_pkg::PIX_W-1:0] out_bin_q, out_bin_d;
  logic                       out_cv_q, out_cv_d;
  logic                       out_df_q, out_df_d;
  logic [tbdc_pkg::POS_W-1:0] out_col_q, out_col_d;
  logic [tbdc_pkg::POS_W-1:0] out_row_q, out_row_d;
  logic                       out_load;
  logic                       accept;
  logic                       dark;
  logic [tbdc_pkg::PIX_W-1:0] bin_pix;
  tbdc_pkg::acc_t             acc_nxt;
  tbdc_pkg::div_req_t         div_req;
  tbdc_pkg::div_rsp_t         div_rsp;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tbdc_pkg::REG_THRESHOLD) ?
                  tbdc_pkg::APB_DATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= tbdc_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == tbdc_pkg::REG_THRESHOLD) begin
      thr_q <= pwdata[tbdc_pkg::PIX_W-1:0];
    end
  end

  assign in_stall_o = !(state_q == tbdc_pkg::ST_IDLE && (!out_valid_q || !out_stall_i));
  assign accept     = in_valid_i && !in_stall_o;
  assign dark       = pixel_i < thr_q;
  assign bin_pix    = dark ? tbdc_pkg::PIX_DARK : tbdc_pkg::PIX_BRIGHT;

  tbdc_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .dark_i (dark),
    .eol_i  (end_of_line_i),
    .eof_i  (end_of_frame_i),
    .nxt_o  (acc_nxt)
  );

  tbdc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d          = state_q;
    out_load         = 1'b0;
    out_bin_d        = bin_pix;
    out_cv_d         = end_of_frame_i;
    out_df_d         = 1'b0;
    out_col_d        = '0;
    out_row_d        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = acc_nxt.col_sum;
    div_req.divisor  = acc_nxt.count;
    case (state_q)
      tbdc_pkg::ST_IDLE: begin
        if (accept) begin
          if (end_of_frame_i && acc_nxt.count != '0) begin
            div_req.start = 1'b1;
            state_d       = tbdc_pkg::ST_DIV_COL;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      tbdc_pkg::ST_DIV_COL: begin
        div_req.dividend = row_sum_q;
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_d       = tbdc_pkg::ST_DIV_ROW;
        end
      end
      tbdc_pkg::ST_DIV_ROW: begin
        out_bin_d = bin_q;
        out_cv_d  = 1'b1;
        out_df_d  = 1'b1;
        out_col_d = col_q;
        out_row_d = div_rsp.quot;
        if (div_rsp.done) begin
          out_load = 1'b1;
          state_d  = tbdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tbdc_pkg::ST_IDLE;
      end
    endcase
    if (state_q != tbdc_pkg::ST_IDLE) begin
      div_req.divisor = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbdc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bin_q     <= bin_pix;
      row_sum_q <= acc_nxt.row_sum;
      count_q   <= acc_nxt.count;
    end
    if (state_q == tbdc_pkg::ST_DIV_COL && div_rsp.done) begin
      col_q <= div_rsp.quot;
    end
    if (out_load) begin
      out_bin_q <= out_bin_d;
      out_cv_q  <= out_cv_d;
      out_df_q  <= out_df_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign binary_pixel_o   = out_bin_q;
  assign centroid_valid_o = out_cv_q;
  assign dark_found_o     = out_df_q;
  assign centroid_col_o   = out_col_q;
  assign centroid_row_o   = out_row_q;

  `TBDC_ASSERT(a_busy_stalls, state_q != tbdc_pkg::ST_IDLE |-> in_stall_o, "Request taken while dividing.")
  `TBDC_ASSERT(a_done_in_div, div_rsp.done |-> (state_q == tbdc_pkg::ST_DIV_COL || state_q == tbdc_pkg::ST_DIV_ROW), "Divider finished outside a division step.")
  `TBDC_ASSERT_NEVER(a_found_needs_eof, out_valid_o && dark_found_o && !centroid_valid_o, "Centroid flag without frame end.")
  `TBDC_ASSERT(a_load_free, out_load |-> (!out_valid_q || !out_stall_i), "Result register overwritten while stalled.")

endmodule
